FILE: src/hssi_pkg.sv
// Shared types, event codes and the half-step coil pattern table for the
// half-step stepper indexer. No dependencies.
package hssi_pkg;

  localparam logic [1:0] KIND_REFRESH = 2'd0;
  localparam logic [1:0] KIND_TRIP    = 2'd1;
  localparam logic [1:0] KIND_STEP    = 2'd2;
  localparam logic [1:0] KIND_PWM     = 2'd3;

  localparam logic [1:0] CFG_RUN_DUTY       = 2'd0;
  localparam logic [1:0] CFG_HOLD_DUTY      = 2'd1;
  localparam logic [1:0] CFG_IDLE_THRESHOLD = 2'd2;

  localparam logic [7:0] RUN_DUTY_RST       = 8'hE0;
  localparam logic [7:0] HOLD_DUTY_RST      = 8'h70;
  localparam logic [7:0] IDLE_THRESHOLD_RST = 8'hA0;

  localparam int unsigned BURST_MAX = 5;

  localparam logic [3:0] COIL_OFF   = 4'h0;
  localparam logic [3:0] COIL_AB    = 4'hA;
  localparam logic [3:0] COIL_CD    = 4'h5;
  localparam logic [3:0] MASK_KEEP_CD = 4'hC;
  localparam logic [3:0] MASK_KEEP_AB = 4'h3;

  typedef struct packed {
    logic [7:0] run_duty;
    logic [7:0] hold_duty;
    logic [7:0] idle_threshold;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] idle_count;
    logic [7:0]  active_duty;
    logic [3:0]  drive_latch;
  } state_t;

  // One event's worth of result beats.
  typedef struct packed {
    logic [2:0]                 count;
    logic [BURST_MAX-1:0][3:0]  coil;
    logic [7:0]                 duty;
    logic                       restart;
  } burst_t;

  function automatic logic [3:0] pattern(input logic [2:0] ph);
    logic [3:0] p;
    case (ph)
      3'd0:    p = 4'h8;
      3'd1:    p = 4'hA;
      3'd2:    p = 4'h2;
      3'd3:    p = 4'h6;
      3'd4:    p = 4'h4;
      3'd5:    p = 4'h5;
      3'd6:    p = 4'h1;
      default: p = 4'h9;
    endcase
    return p;
  endfunction

endpackage

FILE: src/hssi_event.sv
// Event decode: next indexer state and the result burst for one event.
// Depends on hssi_pkg.
module hssi_event (
  input  logic [1:0]      kind,
  input  logic            step_level,
  input  logic            direction,
  input  logic            over_ab,
  input  logic            over_cd,
  input  hssi_pkg::cfg_t   cfg,
  input  hssi_pkg::state_t state,
  output hssi_pkg::state_t state_nxt,
  output hssi_pkg::burst_t burst
);

  logic [2:0] step_phase;
  logic [3:0] trip_pat;
  logic [3:0] step_pat;

  always_comb begin
    step_phase = state.phase;
    if (!step_level) begin
      step_phase = direction ? state.phase + 3'd1 : state.phase - 3'd1;
    end
    step_pat = hssi_pkg::pattern(step_phase);
    trip_pat = hssi_pkg::pattern(state.phase);
    if (over_ab) trip_pat = trip_pat & hssi_pkg::MASK_KEEP_CD;
    if (over_cd) trip_pat = trip_pat & hssi_pkg::MASK_KEEP_AB;
  end

  always_comb begin
    state_nxt     = state;
    burst.count   = 3'd1;
    burst.coil    = '0;
    burst.restart = 1'b0;
    case (kind)
      hssi_pkg::KIND_REFRESH: begin
        burst.count   = 3'd5;
        burst.coil[0] = hssi_pkg::COIL_OFF;
        burst.coil[1] = hssi_pkg::COIL_AB;
        burst.coil[2] = hssi_pkg::COIL_OFF;
        burst.coil[3] = hssi_pkg::COIL_CD;
        burst.coil[4] = state.drive_latch;
      end
      hssi_pkg::KIND_TRIP: begin
        state_nxt.drive_latch = trip_pat;
        burst.coil[0]         = trip_pat;
        burst.restart         = 1'b1;
      end
      hssi_pkg::KIND_STEP: begin
        if (!step_level) begin
          state_nxt.active_duty = cfg.run_duty;
          state_nxt.idle_count  = '0;
          state_nxt.phase       = step_phase;
        end
        state_nxt.drive_latch = step_pat;
        burst.count           = 3'd2;
        burst.coil[0]         = hssi_pkg::COIL_OFF;
        burst.coil[1]         = step_pat;
      end
      default: begin
        if (state.idle_count[15:8] > cfg.idle_threshold) begin
          state_nxt.active_duty = cfg.hold_duty;
        end else begin
          state_nxt.idle_count = state.idle_count + 16'd1;
        end
        burst.coil[0] = state.drive_latch;
      end
    endcase
    burst.duty = state_nxt.active_duty;
  end

endmodule

FILE: src/hssi_burst.sv
// Burst and output registers: play one event's beats out, one per cycle unless
// out_ready stalls; frees the slot as its last beat moves out. Depends on hssi_pkg.
module hssi_burst (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_valid,
  input  hssi_pkg::burst_t load_burst,
  output logic            load_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      out_coil_drive,
  output logic [7:0]      out_duty,
  output logic            out_restart_refresh,
  output logic            out_last
);

  hssi_pkg::burst_t burst_r;
  logic             burst_vld_r;
  logic [2:0]       idx_r;
  logic             out_vld_r;
  logic [3:0]       coil_r;
  logic [7:0]       duty_r;
  logic             restart_r;
  logic             last_r;

  logic emit;
  logic final_beat;
  logic take;

  assign emit       = burst_vld_r && (!out_vld_r || out_ready);
  assign final_beat = (idx_r == burst_r.count - 3'd1);
  assign load_ready = !burst_vld_r || (emit && final_beat);
  assign take       = load_valid && load_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_vld_r <= 1'b0;
      idx_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (take) begin
        burst_vld_r <= 1'b1;
        idx_r       <= '0;
      end else if (emit) begin
        if (final_beat) burst_vld_r <= 1'b0;
        idx_r <= idx_r + 3'd1;
      end
      if (emit) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) burst_r <= load_burst;
    if (emit) begin
      coil_r    <= burst_r.coil[idx_r];
      duty_r    <= burst_r.duty;
      restart_r <= burst_r.restart;
      last_r    <= final_beat;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_coil_drive      = coil_r;
  assign out_duty            = duty_r;
  assign out_restart_refresh = restart_r;
  assign out_last            = last_r;

endmodule

FILE: src/half_step_stepper_indexer_core.sv
// Half-step step/dir stepper indexer, top level.
// An event's beats pass through the burst register, then the output register.
// Throughput: one trip or PWM event per cycle and one output beat per cycle,
// unless out_ready stalls; steps and refreshes wait until their last beat goes.
// Reset (rst_n low, synchronous): phase 0, idle count 0, duty 224, latch 8,
// registers at 224/112/160, no beats pending.
module half_step_stepper_indexer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic       in_step_level,
  input  logic       in_direction,
  input  logic       in_over_ab,
  input  logic       in_over_cd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_coil_drive,
  output logic [7:0] out_duty,
  output logic       out_restart_refresh,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  hssi_pkg::cfg_t   cfg_r;
  hssi_pkg::state_t state_r;
  hssi_pkg::state_t state_nxt;
  hssi_pkg::burst_t burst;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_duty       <= hssi_pkg::RUN_DUTY_RST;
      cfg_r.hold_duty      <= hssi_pkg::HOLD_DUTY_RST;
      cfg_r.idle_threshold <= hssi_pkg::IDLE_THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        hssi_pkg::CFG_RUN_DUTY:       cfg_r.run_duty       <= cfg_data;
        hssi_pkg::CFG_HOLD_DUTY:      cfg_r.hold_duty      <= cfg_data;
        hssi_pkg::CFG_IDLE_THRESHOLD: cfg_r.idle_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // state advances at the accept edge; the burst carries the updated duty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= '0;
      state_r.idle_count  <= '0;
      state_r.active_duty <= hssi_pkg::RUN_DUTY_RST;
      state_r.drive_latch <= hssi_pkg::pattern(3'd0);
    end else if (in_valid && in_ready) begin
      state_r <= state_nxt;
    end
  end

  hssi_event u_event (
    .kind       (in_kind),
    .step_level (in_step_level),
    .direction  (in_direction),
    .over_ab    (in_over_ab),
    .over_cd    (in_over_cd),
    .cfg        (cfg_r),
    .state      (state_r),
    .state_nxt  (state_nxt),
    .burst      (burst)
  );

  hssi_burst u_burst (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load_valid          (in_valid),
    .load_burst          (burst),
    .load_ready          (in_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_coil_drive      (out_coil_drive),
    .out_duty            (out_duty),
    .out_restart_refresh (out_restart_refresh),
    .out_last            (out_last)
  );

endmodule
